[rtl/core/vec3_fixed_point_alu_macros.svh]
// Assertion macros for the vector ALU.
`ifndef VEC3_FIXED_POINT_ALU_MACROS_SVH
`define VEC3_FIXED_POINT_ALU_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define VFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Condition that must never be seen outside reset.
`define VFA_ASSERT_NEVER(lbl, bad, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(bad)) else $error(msg);
`endif

[rtl/core/vfa_pkg.sv]
// Shared opcode and pipeline control types for the vector ALU.
`default_nettype none
package vfa_pkg;
  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_NEG    = 3'd2,
    OP_DOT    = 3'd3,
    OP_CROSS  = 3'd4,
    OP_SCALE  = 3'd5,
    OP_LENGTH = 3'd6,
    OP_NORM   = 3'd7
  } opcode_t;

  // Global advance and the valid bit entering a unit.
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;
endpackage
`default_nettype wire

[rtl/core/vfa_front.sv]
// Front end: operand capture, product bank and sums with saturation.
`default_nettype none
module vfa_front import vfa_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pipe_ctl_t             ctl,
  input  logic [2:0]            opcode,
  input  logic signed [31:0]    a_x,
  input  logic signed [31:0]    a_y,
  input  logic signed [31:0]    a_z,
  input  logic signed [31:0]    b_x,
  input  logic signed [31:0]    b_y,
  input  logic signed [31:0]    b_z,
  input  logic signed [31:0]    factor,
  output logic                  valid_out,
  output opcode_t               op_out,
  output logic [2:0][W-1:0]     r_out,
  output logic [W-1:0]          s_out,
  output logic                  flag_out,
  output logic [2:0]            sgn_out,
  output logic [2:0][W-1:0]     mag_out,
  output logic [2*W-1:0]        sq_out
);
  localparam int BW = 2 * W + 2;
  localparam logic signed [BW-1:0] MAXV = {{(BW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [BW-1:0] MINV = {{(BW-W+1){1'b1}}, {(W-1){1'b0}}};

  function automatic logic [W:0] sat_fn(input logic signed [BW-1:0] x);
    logic [W:0] res;
    if (x > MAXV) res = {1'b1, MAXV[W-1:0]};
    else if (x < MINV) res = {1'b1, MINV[W-1:0]};
    else res = {1'b0, x[W-1:0]};
    return res;
  endfunction

  // stage 1: operands
  logic                v1;
  opcode_t             op1;
  logic signed [W-1:0] a1 [3];
  logic signed [W-1:0] b1 [3];
  logic signed [W-1:0] f1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (ctl.en) v1 <= ctl.valid;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      op1   <= opcode_t'(opcode);
      a1[0] <= W'(a_x);
      a1[1] <= W'(a_y);
      a1[2] <= W'(a_z);
      b1[0] <= W'(b_x);
      b1[1] <= W'(b_y);
      b1[2] <= W'(b_z);
      f1    <= W'(factor);
    end
  end

  // stage 2: products, add/sub/negate
  logic signed [W-1:0]   ma [6];
  logic signed [W-1:0]   mb [6];
  logic signed [W:0]     as_sum [3];
  logic [W:0]            as_sat [3];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    case (op1)
      OP_CROSS: begin
        ma[0] = a1[1]; mb[0] = b1[2];
        ma[1] = a1[2]; mb[1] = b1[1];
        ma[2] = a1[2]; mb[2] = b1[0];
        ma[3] = a1[0]; mb[3] = b1[2];
        ma[4] = a1[0]; mb[4] = b1[1];
        ma[5] = a1[1]; mb[5] = b1[0];
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          ma[2*i] = a1[i]; mb[2*i] = f1;
        end
      end
      OP_LENGTH, OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          ma[2*i] = a1[i]; mb[2*i] = a1[i];
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          ma[2*i] = a1[i]; mb[2*i] = b1[i];
        end
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (op1)
        OP_ADD:  as_sum[i] = (W+1)'(a1[i]) + (W+1)'(b1[i]);
        OP_SUB:  as_sum[i] = (W+1)'(a1[i]) - (W+1)'(b1[i]);
        default: as_sum[i] = (W+1)'(0) - (W+1)'(a1[i]);
      endcase
      as_sat[i] = sat_fn(BW'(as_sum[i]));
    end
  end

  logic                  v2;
  opcode_t               op2;
  logic signed [2*W-1:0] p2 [6];
  logic [W-1:0]          as2 [3];
  logic                  asf2;
  logic [2:0]            sgn2;
  logic [2:0][W-1:0]     mag2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (ctl.en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      op2  <= op1;
      asf2 <= as_sat[0][W] | as_sat[1][W] | as_sat[2][W];
      for (int i = 0; i < 6; i++) p2[i] <= (2*W)'(ma[i]) * (2*W)'(mb[i]);
      for (int i = 0; i < 3; i++) begin
        as2[i]  <= as_sat[i][W-1:0];
        sgn2[i] <= a1[i][W-1];
        mag2[i] <= a1[i][W-1] ? W'(0) - a1[i] : a1[i];
      end
    end
  end

  // stage 3: sums, shifts and clamps
  logic signed [BW-1:0] acc;
  logic [W:0]           dot_sat;
  logic [W:0]           cr_sat [3];
  logic [W:0]           sc_sat [3];
  logic [2:0][W-1:0]    r_n;
  logic [W-1:0]         s_n;
  logic                 fl_n;

  always_comb begin
    acc     = BW'(p2[0]) + BW'(p2[2]) + BW'(p2[4]);
    dot_sat = sat_fn(acc >>> F);
    for (int i = 0; i < 3; i++) begin
      cr_sat[i] = sat_fn((BW'(p2[2*i]) - BW'(p2[2*i+1])) >>> F);
      sc_sat[i] = sat_fn(BW'(p2[2*i]) >>> F);
    end
    r_n  = '0;
    s_n  = '0;
    fl_n = 1'b0;
    case (op2)
      OP_ADD, OP_SUB, OP_NEG: begin
        for (int i = 0; i < 3; i++) r_n[i] = as2[i];
        fl_n = asf2;
      end
      OP_DOT: begin
        s_n  = dot_sat[W-1:0];
        fl_n = dot_sat[W];
      end
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) r_n[i] = cr_sat[i][W-1:0];
        fl_n = cr_sat[0][W] | cr_sat[1][W] | cr_sat[2][W];
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) r_n[i] = sc_sat[i][W-1:0];
        fl_n = sc_sat[0][W] | sc_sat[1][W] | sc_sat[2][W];
      end
      default: begin
        fl_n = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) valid_out <= 1'b0;
    else if (ctl.en) valid_out <= v2;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      op_out   <= op2;
      r_out    <= r_n;
      s_out    <= s_n;
      flag_out <= fl_n;
      sgn_out  <= sgn2;
      mag_out  <= mag2;
      sq_out   <= acc[2*W-1:0];
    end
  end
endmodule
`default_nettype wire

[rtl/core/vfa_sqrt.sv]
// Pipelined digit-by-digit integer square root, one root bit per stage.
`default_nettype none
module vfa_sqrt import vfa_pkg::*; #(
  parameter int W   = 32,
  parameter int SBW = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  pipe_ctl_t      ctl,
  input  logic [2*W-1:0] rad_in,
  input  logic [SBW-1:0] sb_in,
  output logic           valid_out,
  output logic [W-1:0]   root_out,
  output logic [SBW-1:0] sb_out
);
  logic           vld  [W];
  logic [W+1:0]   rem  [W];
  logic [W-1:0]   root [W];
  logic [2*W-1:0] rad  [W];
  logic [SBW-1:0] sb   [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic           v_i;
    logic [W+1:0]   rem_i;
    logic [W-1:0]   root_i;
    logic [2*W-1:0] rad_i;
    logic [SBW-1:0] sb_i;
    logic [W+1:0]   rem_sh;
    logic [W+1:0]   trial;

    if (k == 0) begin : g_first
      assign v_i    = ctl.valid;
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = rad_in;
      assign sb_i   = sb_in;
    end else begin : g_next
      assign v_i    = vld[k-1];
      assign rem_i  = rem[k-1];
      assign root_i = root[k-1];
      assign rad_i  = rad[k-1];
      assign sb_i   = sb[k-1];
    end

    assign rem_sh = {rem_i[W-1:0], rad_i[2*W-1:2*W-2]};
    assign trial  = {root_i, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else if (ctl.en) vld[k] <= v_i;
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rad[k] <= {rad_i[2*W-3:0], 2'b00};
        sb[k]  <= sb_i;
        if (rem_sh >= trial) begin
          rem[k]  <= rem_sh - trial;
          root[k] <= {root_i[W-2:0], 1'b1};
        end else begin
          rem[k]  <= rem_sh;
          root[k] <= {root_i[W-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_out = vld[W-1];
  assign root_out  = root[W-1];
  assign sb_out    = sb[W-1];
endmodule
`default_nettype wire

[rtl/core/vfa_div.sv]
// Pipelined restoring divider, three lanes sharing one divisor.
`default_nettype none
module vfa_div import vfa_pkg::*; #(
  parameter int W   = 32,
  parameter int QW  = 48,
  parameter int SBW = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  pipe_ctl_t         ctl,
  input  logic [2:0][QW-1:0] num_in,
  input  logic [W-1:0]      den_in,
  input  logic [SBW-1:0]    sb_in,
  output logic              valid_out,
  output logic [2:0][QW-1:0] quo_out,
  output logic [SBW-1:0]    sb_out
);
  logic               vld [QW];
  logic [2:0][W-1:0]  rem [QW];
  logic [2:0][QW-1:0] nq  [QW];   // dividend bits shift out, quotient bits shift in
  logic [W-1:0]       den [QW];
  logic [SBW-1:0]     sb  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic               v_i;
    logic [2:0][W-1:0]  rem_i;
    logic [2:0][QW-1:0] nq_i;
    logic [W-1:0]       den_i;
    logic [SBW-1:0]     sb_i;
    logic [W:0]         rem_sh [3];

    if (k == 0) begin : g_first
      assign v_i   = ctl.valid;
      assign rem_i = '0;
      assign nq_i  = num_in;
      assign den_i = den_in;
      assign sb_i  = sb_in;
    end else begin : g_next
      assign v_i   = vld[k-1];
      assign rem_i = rem[k-1];
      assign nq_i  = nq[k-1];
      assign den_i = den[k-1];
      assign sb_i  = sb[k-1];
    end

    always_comb begin
      for (int l = 0; l < 3; l++) rem_sh[l] = {rem_i[l], nq_i[l][QW-1]};
    end

    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else if (ctl.en) vld[k] <= v_i;
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        den[k] <= den_i;
        sb[k]  <= sb_i;
        for (int l = 0; l < 3; l++) begin
          if (rem_sh[l] >= {1'b0, den_i}) begin
            rem[k][l] <= W'(rem_sh[l] - {1'b0, den_i});
            nq[k][l]  <= {nq_i[l][QW-2:0], 1'b1};
          end else begin
            rem[k][l] <= rem_sh[l][W-1:0];
            nq[k][l]  <= {nq_i[l][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign valid_out = vld[QW-1];
  assign quo_out   = nq[QW-1];
  assign sb_out    = sb[QW-1];
endmodule
`default_nettype wire

[rtl/core/vec3_fixed_point_alu.sv]
// Top level of the pipelined three-component fixed-point vector ALU.
//
//  channel | signals                                   | dir | role
//  --------+-------------------------------------------+-----+--------------------------
//  in      | in_valid, in_ready, opcode, a_*, b_*, factor | in  | one request per op
//  out     | out_valid, out_ready, r_*, scalar_out, flags | out | one result per request
//
// One request enters per clock while the output register is not stalled; nothing iterates in place.
// Every request passes three front stages, one square-root stage per root bit, one divider
// stage per quotient bit, and the output register (the defaults give Q16.16). Every opcode
// takes the full path so order is kept.
// A stalled output register freezes the whole pipeline; in_ready drops with it.
// Reset (synchronous) clears the valid bits only.
`default_nettype none
`include "vec3_fixed_point_alu_macros.svh"
module vec3_fixed_point_alu import vfa_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int COMP_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] a_z,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] b_z,
  input  logic signed [31:0] factor,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] r_x,
  output logic signed [31:0] r_y,
  output logic signed [31:0] r_z,
  output logic signed [31:0] scalar_out,
  output logic               saturated,
  output logic               zero_length_error
);
  localparam int W   = COMP_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int QW  = W + F;              // normalise quotient width
  localparam int SB1 = 3 + 4 * W + 1 + 3 + 3 * W;
  localparam int SB2 = 3 + 4 * W + 1 + 3 + W;
  localparam logic [QW-1:0] POS_LIM = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [QW-1:0] NEG_LIM = POS_LIM + QW'(1);

  // single advance for the whole pipe, driven by the output register
  logic      en;
  pipe_ctl_t ctl_front;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign ctl_front = '{en: en, valid: in_valid};

  // front end
  logic              fv;
  opcode_t           f_op;
  logic [2:0][W-1:0] f_r;
  logic [W-1:0]      f_s;
  logic              f_fl;
  logic [2:0]        f_sgn;
  logic [2:0][W-1:0] f_mag;
  logic [2*W-1:0]    f_sq;

  vfa_front #(.W(W), .F(F)) u_front (
    .clk, .rst, .ctl(ctl_front), .opcode,
    .a_x, .a_y, .a_z, .b_x, .b_y, .b_z, .factor,
    .valid_out(fv), .op_out(f_op), .r_out(f_r), .s_out(f_s), .flag_out(f_fl),
    .sgn_out(f_sgn), .mag_out(f_mag), .sq_out(f_sq)
  );

  // length
  pipe_ctl_t      ctl_sq;
  logic [SB1-1:0] sq_sb_in, sq_sb_out;
  logic           sv;
  logic [W-1:0]   len;
  assign ctl_sq   = '{en: en, valid: fv};
  assign sq_sb_in = {f_op, f_r, f_s, f_fl, f_sgn, f_mag};

  vfa_sqrt #(.W(W), .SBW(SB1)) u_sqrt (
    .clk, .rst, .ctl(ctl_sq), .rad_in(f_sq), .sb_in(sq_sb_in),
    .valid_out(sv), .root_out(len), .sb_out(sq_sb_out)
  );

  opcode_t           s_op;
  logic [2:0][W-1:0] s_r;
  logic [W-1:0]      s_s;
  logic              s_fl;
  logic [2:0]        s_sgn;
  logic [2:0][W-1:0] s_mag;
  assign {s_op, s_r, s_s, s_fl, s_sgn, s_mag} = sq_sb_out;

  // normalise: |a| << F over the length
  pipe_ctl_t          ctl_dv;
  logic [2:0][QW-1:0] num;
  logic [SB2-1:0]     dv_sb_in, dv_sb_out;
  logic               dv;
  logic [2:0][QW-1:0] quo;
  assign ctl_dv   = '{en: en, valid: sv};
  assign dv_sb_in = {s_op, s_r, s_s, s_fl, s_sgn, len};
  always_comb begin
    for (int i = 0; i < 3; i++) num[i] = {s_mag[i], {F{1'b0}}};
  end

  vfa_div #(.W(W), .QW(QW), .SBW(SB2)) u_div (
    .clk, .rst, .ctl(ctl_dv), .num_in(num), .den_in(len), .sb_in(dv_sb_in),
    .valid_out(dv), .quo_out(quo), .sb_out(dv_sb_out)
  );

  opcode_t           d_op;
  logic [2:0][W-1:0] d_r;
  logic [W-1:0]      d_s;
  logic              d_fl;
  logic [2:0]        d_sgn;
  logic [W-1:0]      d_len;
  assign {d_op, d_r, d_s, d_fl, d_sgn, d_len} = dv_sb_out;

  // result select and final clamps
  logic [2:0][W-1:0] r_n;
  logic [W-1:0]      s_n;
  logic              fl_n;
  logic              ze_n;
  logic [QW-1:0]     qneg [3];

  always_comb begin
    r_n  = d_r;
    s_n  = d_s;
    fl_n = d_fl;
    ze_n = 1'b0;
    for (int i = 0; i < 3; i++) qneg[i] = QW'(0) - quo[i];
    case (d_op)
      OP_LENGTH: begin
        r_n = '0;
        if (d_len[W-1]) begin
          s_n  = POS_LIM[W-1:0];
          fl_n = 1'b1;
        end else begin
          s_n  = d_len;
          fl_n = 1'b0;
        end
      end
      OP_NORM: begin
        s_n  = '0;
        r_n  = '0;
        fl_n = 1'b0;
        if (d_len == '0) begin
          ze_n = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (d_sgn[i]) begin
              if (quo[i] > NEG_LIM) begin
                r_n[i] = NEG_LIM[W-1:0];
                fl_n   = 1'b1;
              end else begin
                r_n[i] = qneg[i][W-1:0];
              end
            end else begin
              if (quo[i] > POS_LIM) begin
                r_n[i] = POS_LIM[W-1:0];
                fl_n   = 1'b1;
              end else begin
                r_n[i] = quo[i][W-1:0];
              end
            end
          end
        end
      end
      default: begin
        ze_n = 1'b0;
      end
    endcase
  end

  // output register
  logic signed [W-1:0] rx, ry, rz, rs;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dv;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx                <= r_n[0];
      ry                <= r_n[1];
      rz                <= r_n[2];
      rs                <= s_n;
      saturated         <= fl_n;
      zero_length_error <= ze_n;
    end
  end

  // components leave sign-extended or truncated to the port width
  assign r_x        = 32'(rx);
  assign r_y        = 32'(ry);
  assign r_z        = 32'(rz);
  assign scalar_out = 32'(rs);

  `VFA_ASSERT_IMP(a_zero_len_clear, out_valid && zero_length_error, r_x == 0 && r_y == 0 && r_z == 0 && scalar_out == 0, "zero-length normalise result not cleared")
  `VFA_ASSERT_IMP(a_scalar_excl, out_valid && scalar_out != 0, r_x == 0 && r_y == 0 && r_z == 0, "scalar result with non-zero vector")
  `VFA_ASSERT_NEVER(a_err_no_sat, out_valid && zero_length_error && saturated, "zero-length error with saturation")
endmodule
`default_nettype wire
